@@ design/tes_pkg.sv @@
// Shared types and constants for the text encoding sniffer.
package tes_pkg;

   localparam int MAX_SAMPLE_BYTES = 65536;
   localparam int CountWidth       = $clog2(MAX_SAMPLE_BYTES + 1);

   localparam logic [2:0] MODE_AUTO   = 3'd0;
   localparam logic [2:0] MODE_UTF8   = 3'd1;
   localparam logic [2:0] MODE_UTF16L = 3'd2;
   localparam logic [2:0] MODE_UTF16B = 3'd3;
   localparam logic [2:0] MODE_SYSTEM = 3'd4;

   typedef enum logic [1:0] {
      ENC_UTF8    = 2'd0,
      ENC_UTF16LE = 2'd1,
      ENC_UTF16BE = 2'd2,
      ENC_SYSTEM  = 2'd3
   } encoding_type;

   // Allowed range for the byte after a lead byte.
   typedef enum logic [2:0] {
      SBC_ANY   = 3'd0,
      SBC_A0_BF = 3'd1,
      SBC_80_9F = 3'd2,
      SBC_90_BF = 3'd3,
      SBC_80_8F = 3'd4,
      SBC_NONE  = 3'd5
   } second_class_type;

   typedef struct packed {
      logic [1:0]       cont_left;
      second_class_type second_class;
      logic             committed_err;
      logic             open_err;
   } utf8_state_type;

endpackage

@@ design/text_encoding_sniffer.sv @@
// Top level of the text encoding sniffer: BOM, NUL ratio and UTF-8 checks.
//
// Usage:
//  - req_*: one sample byte per beat, req_tlast on the final byte of a sample.
//  - rsp_*: one result beat per sample, issued for the beat carrying req_tlast.
//  - csr_*: forced_mode register (0 auto, 1 utf8, 2 utf16 le, 3 utf16 be,
//    4 system); write only while no sample is in flight.
// Throughput: one byte per cycle unless the full result register stalls input.
// All per-byte updates (head capture, NUL counters, UTF-8 validator) and the
// final decision are combinational between the sample state registers and the
// result register, which is valid in the cycle after the last byte is accepted.
// Reset (synchronous, active high) clears the sample state, the mode register
// and the result valid flag.
// Stall: the single result register holds while rsp_tready is low; input is
// still taken as long as the result register is empty or draining that cycle,
// so rsp_tready high keeps the stream moving back to back.
// Bytes beyond MAX_SAMPLE_BYTES are dropped; their tlast still ends the sample.
module text_encoding_sniffer (
   input  logic       clock,
   input  logic       reset,
   // config
   input  logic       csr_we,
   input  logic [2:0] csr_wdata,   // forced_mode
   // sample bytes
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   // results
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [1:0] encoding_code, [3:2] bom_length,
                                   // [5:4] unit_size, [7:6] zero
);
   import tes_pkg::*;

   // sample state
   logic [2:0]            mode_ff;
   logic [23:0]           head_ff, head_in;
   logic [CountWidth-1:0] count_ff, count_in, count_upd;
   logic [CountWidth-1:0] nul_even_ff, nul_even_in, nul_even_upd;
   logic [CountWidth-1:0] nul_odd_ff, nul_odd_in, nul_odd_upd;
   utf8_state_type        utf_ff, utf_in, utf_step, utf_upd;
   logic [23:0]           head_upd;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   encoding_type          enc_ff, enc_in;
   logic [1:0]            bom_ff, bom_in;
   logic [1:0]            unit_ff, unit_in;

   logic                  accept;
   logic                  in_range;
   logic                  bom8, bomle, bombe;
   logic [CountWidth+2:0] nul_sum, nul_x5;
   logic                  nul_heavy;
   encoding_type          enc_dec;
   logic [1:0]            bom_dec, unit_dec;

   // output register frees up the same cycle it is drained
   assign req_tready = ~rsp_valid_ff | rsp_tready;
   assign accept     = req_tvalid & req_tready;
   assign in_range   = count_ff < CountWidth'(MAX_SAMPLE_BYTES);

   tes_utf8_step u_utf8 (
      .cur_state (utf_ff),
      .data_byte (req_tdata),
      .nxt_state (utf_step)
   );

   // per-byte update, gated by the sample size limit
   always_comb begin
      head_upd     = head_ff;
      count_upd    = count_ff;
      nul_even_upd = nul_even_ff;
      nul_odd_upd  = nul_odd_ff;
      utf_upd      = utf_ff;
      if (in_range) begin
         if (count_ff < CountWidth'(3)) begin
            case (count_ff[1:0])
               2'd0:    head_upd[7:0]   = req_tdata;
               2'd1:    head_upd[15:8]  = req_tdata;
               default: head_upd[23:16] = req_tdata;
            endcase
         end
         if (req_tdata == 8'h00) begin
            if (count_ff[0]) begin
               nul_odd_upd = nul_odd_ff + CountWidth'(1);
            end else begin
               nul_even_upd = nul_even_ff + CountWidth'(1);
            end
         end
         utf_upd   = utf_step;
         count_upd = count_ff + CountWidth'(1);
      end
   end

   // decision on the updated state
   always_comb begin
      bom8  = (count_upd >= CountWidth'(3)) && head_upd[7:0] == 8'hEF
              && head_upd[15:8] == 8'hBB && head_upd[23:16] == 8'hBF;
      bomle = (count_upd >= CountWidth'(2)) && head_upd[7:0] == 8'hFF
              && head_upd[15:8] == 8'hFE;
      bombe = (count_upd >= CountWidth'(2)) && head_upd[7:0] == 8'hFE
              && head_upd[15:8] == 8'hFF;
      // more than a fifth NULs: 5 * nuls > count
      nul_sum   = (CountWidth+3)'(nul_even_upd) + (CountWidth+3)'(nul_odd_upd);
      nul_x5    = (nul_sum << 2) + nul_sum;
      nul_heavy = nul_x5 > (CountWidth+3)'(count_upd);
   end

   always_comb begin
      enc_dec  = ENC_UTF8;
      bom_dec  = 2'd0;
      unit_dec = 2'd1;
      case (mode_ff)
         MODE_AUTO: begin
            if (bom8) begin
               bom_dec = 2'd3;
            end else if (bomle) begin
               enc_dec  = ENC_UTF16LE;
               bom_dec  = 2'd2;
               unit_dec = 2'd2;
            end else if (bombe) begin
               enc_dec  = ENC_UTF16BE;
               bom_dec  = 2'd2;
               unit_dec = 2'd2;
            end else if (nul_heavy) begin
               enc_dec  = (nul_odd_upd >= nul_even_upd) ? ENC_UTF16LE : ENC_UTF16BE;
               unit_dec = 2'd2;
            end else if (utf_upd.committed_err) begin
               enc_dec = ENC_SYSTEM;
            end
         end
         MODE_UTF8: begin
            bom_dec = bom8 ? 2'd3 : 2'd0;
         end
         MODE_UTF16L: begin
            enc_dec  = ENC_UTF16LE;
            bom_dec  = bomle ? 2'd2 : 2'd0;
            unit_dec = 2'd2;
         end
         MODE_UTF16B: begin
            enc_dec  = ENC_UTF16BE;
            bom_dec  = bombe ? 2'd2 : 2'd0;
            unit_dec = 2'd2;
         end
         MODE_SYSTEM: begin
            enc_dec = ENC_SYSTEM;
         end
         default: begin
            // unused modes fall back to utf8, no BOM
         end
      endcase
   end

   // next-state selection: clear after the last byte
   always_comb begin
      head_in      = head_ff;
      count_in     = count_ff;
      nul_even_in  = nul_even_ff;
      nul_odd_in   = nul_odd_ff;
      utf_in       = utf_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      enc_in       = enc_ff;
      bom_in       = bom_ff;
      unit_in      = unit_ff;
      if (accept) begin
         if (req_tlast) begin
            head_in      = '0;
            count_in     = '0;
            nul_even_in  = '0;
            nul_odd_in   = '0;
            utf_in       = '0;
            rsp_valid_in = 1'b1;
            enc_in       = enc_dec;
            bom_in       = bom_dec;
            unit_in      = unit_dec;
         end else begin
            head_in     = head_upd;
            count_in    = count_upd;
            nul_even_in = nul_even_upd;
            nul_odd_in  = nul_odd_upd;
            utf_in      = utf_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_AUTO;
         head_ff      <= '0;
         count_ff     <= '0;
         nul_even_ff  <= '0;
         nul_odd_ff   <= '0;
         utf_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         head_ff      <= head_in;
         count_ff     <= count_in;
         nul_even_ff  <= nul_even_in;
         nul_odd_ff   <= nul_odd_in;
         utf_ff       <= utf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      enc_ff  <= enc_in;
      bom_ff  <= bom_in;
      unit_ff <= unit_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, unit_ff, bom_ff, enc_ff};

endmodule

@@ design/tes_utf8_step.sv @@
// Strict UTF-8 validator: next validator state for one byte.
module tes_utf8_step (
   input  tes_pkg::utf8_state_type cur_state,
   input  logic [7:0]              data_byte,
   output tes_pkg::utf8_state_type nxt_state
);
   import tes_pkg::*;

   logic second_ok;
   logic do_start;

   always_comb begin
      case (cur_state.second_class)
         SBC_ANY:   second_ok = 1'b1;
         SBC_A0_BF: second_ok = data_byte >= 8'hA0;
         SBC_80_9F: second_ok = data_byte <= 8'h9F;
         SBC_90_BF: second_ok = data_byte >= 8'h90;
         SBC_80_8F: second_ok = data_byte <= 8'h8F;
         default:   second_ok = 1'b0;
      endcase
   end

   always_comb begin
      nxt_state = cur_state;
      do_start  = 1'b1;
      if (cur_state.cont_left != 2'd0) begin
         if (data_byte[7:6] == 2'b10) begin
            do_start               = 1'b0;
            nxt_state.second_class = SBC_ANY;
            nxt_state.cont_left    = cur_state.cont_left - 2'd1;
            nxt_state.open_err     = cur_state.open_err | ~second_ok;
            if (cur_state.cont_left == 2'd1) begin
               // sequence complete: its error becomes permanent
               nxt_state.committed_err = cur_state.committed_err | nxt_state.open_err;
               nxt_state.open_err      = 1'b0;
            end
         end else begin
            // broken sequence; this byte opens a new one
            nxt_state.committed_err = 1'b1;
            nxt_state.open_err      = 1'b0;
            nxt_state.cont_left     = 2'd0;
            nxt_state.second_class  = SBC_ANY;
         end
      end
      if (do_start) begin
         if (data_byte[7] == 1'b0) begin
            // plain ASCII
         end else if (data_byte[7:5] == 3'b110) begin
            nxt_state.cont_left    = 2'd1;
            nxt_state.second_class = (data_byte < 8'hC2) ? SBC_NONE : SBC_ANY;
         end else if (data_byte[7:4] == 4'b1110) begin
            nxt_state.cont_left = 2'd2;
            if (data_byte == 8'hE0) begin
               nxt_state.second_class = SBC_A0_BF;
            end else if (data_byte == 8'hED) begin
               nxt_state.second_class = SBC_80_9F;
            end else begin
               nxt_state.second_class = SBC_ANY;
            end
         end else if (data_byte[7:3] == 5'b11110) begin
            nxt_state.cont_left = 2'd3;
            if (data_byte == 8'hF0) begin
               nxt_state.second_class = SBC_90_BF;
            end else if (data_byte == 8'hF4) begin
               nxt_state.second_class = SBC_80_8F;
            end else if (data_byte > 8'hF4) begin
               nxt_state.second_class = SBC_NONE;
            end else begin
               nxt_state.second_class = SBC_ANY;
            end
         end else begin
            // stray continuation or F8..FF
            nxt_state.committed_err = 1'b1;
         end
      end
   end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for text_encoding_sniffer: random and directed samples, predicted results.
module tb_top;
   import tes_pkg::*;

   // Result beat as it sits on rsp_tdata; the last member lands in the lowest bits.
   typedef struct packed {
      logic [1:0]   pad;
      logic [1:0]   unit_size;
      logic [1:0]   bom_length;
      encoding_type encoding;
   } sniff_result_type;

   class sniff_scoreboard;
      logic [2:0]       mode;
      logic [7:0]       head [3];
      int unsigned      nbytes;
      int unsigned      nul_even;
      int unsigned      nul_odd;
      logic [1:0]       cont_left;
      second_class_type sbc;
      bit               committed_err;
      bit               open_err;
      sniff_result_type expected_encodings [$];
      int unsigned      errors;

      function new();
         mode   = MODE_AUTO;
         errors = 0;
         clear_sample();
      endfunction

      function void clear_sample();
         head          = '{8'h00, 8'h00, 8'h00};
         nbytes        = 0;
         nul_even      = 0;
         nul_odd       = 0;
         cont_left     = 2'd0;
         sbc           = SBC_ANY;
         committed_err = 1'b0;
         open_err      = 1'b0;
      endfunction

      function void set_mode(logic [2:0] m);
         mode = m;
      endfunction

      function int pending();
         return expected_encodings.size();
      endfunction

      // Track one accepted byte; on the final byte, predict the result beat.
      function void note_byte(logic [7:0] b, logic last);
         sniff_result_type r;
         bit ok;
         bit bom8, bomle, bombe;
         if (nbytes < MAX_SAMPLE_BYTES) begin
            if (nbytes < 3) head[nbytes] = b;
            if (b == 8'h00) begin
               if (nbytes % 2 == 1) nul_odd++;
               else nul_even++;
            end
            if (cont_left != 2'd0 && b[7:6] == 2'b10) begin
               case (sbc)
                  SBC_ANY:   ok = 1'b1;
                  SBC_A0_BF: ok = (b >= 8'hA0);
                  SBC_80_9F: ok = (b <= 8'h9F);
                  SBC_90_BF: ok = (b >= 8'h90);
                  SBC_80_8F: ok = (b <= 8'h8F);
                  default:   ok = 1'b0;
               endcase
               if (!ok) open_err = 1'b1;
               sbc = SBC_ANY;
               cont_left--;
               if (cont_left == 2'd0) begin
                  if (open_err) committed_err = 1'b1;
                  open_err = 1'b0;
               end
            end else begin
               // non-continuation inside a sequence breaks it, then starts fresh
               if (cont_left != 2'd0) begin
                  committed_err = 1'b1;
                  open_err      = 1'b0;
                  cont_left     = 2'd0;
                  sbc           = SBC_ANY;
               end
               if (b[7] == 1'b0) begin
                  ok = 1'b1;
               end else if (b[7:5] == 3'b110) begin
                  cont_left = 2'd1;
                  sbc       = (b < 8'hC2) ? SBC_NONE : SBC_ANY;
               end else if (b[7:4] == 4'b1110) begin
                  cont_left = 2'd2;
                  sbc       = (b == 8'hE0) ? SBC_A0_BF : (b == 8'hED) ? SBC_80_9F : SBC_ANY;
               end else if (b[7:3] == 5'b11110) begin
                  cont_left = 2'd3;
                  sbc       = (b == 8'hF0) ? SBC_90_BF : (b == 8'hF4) ? SBC_80_8F :
                              (b > 8'hF4) ? SBC_NONE : SBC_ANY;
               end else begin
                  committed_err = 1'b1;
               end
            end
            nbytes++;
         end
         if (!last) return;

         bom8  = nbytes >= 3 && head[0] == 8'hEF && head[1] == 8'hBB && head[2] == 8'hBF;
         bomle = nbytes >= 2 && head[0] == 8'hFF && head[1] == 8'hFE;
         bombe = nbytes >= 2 && head[0] == 8'hFE && head[1] == 8'hFF;
         r = '0;
         r.encoding  = ENC_UTF8;
         r.unit_size = 2'd1;
         case (mode)
            MODE_AUTO: begin
               if (bom8) begin
                  r.bom_length = 2'd3;
               end else if (bomle) begin
                  r.encoding = ENC_UTF16LE; r.bom_length = 2'd2; r.unit_size = 2'd2;
               end else if (bombe) begin
                  r.encoding = ENC_UTF16BE; r.bom_length = 2'd2; r.unit_size = 2'd2;
               end else if (5 * (nul_even + nul_odd) > nbytes) begin
                  r.encoding  = (nul_odd >= nul_even) ? ENC_UTF16LE : ENC_UTF16BE;
                  r.unit_size = 2'd2;
               end else begin
                  r.encoding = committed_err ? ENC_SYSTEM : ENC_UTF8;
               end
            end
            MODE_UTF8: r.bom_length = bom8 ? 2'd3 : 2'd0;
            MODE_UTF16L: begin
               r.encoding = ENC_UTF16LE; r.bom_length = bomle ? 2'd2 : 2'd0; r.unit_size = 2'd2;
            end
            MODE_UTF16B: begin
               r.encoding = ENC_UTF16BE; r.bom_length = bombe ? 2'd2 : 2'd0; r.unit_size = 2'd2;
            end
            MODE_SYSTEM: r.encoding = ENC_SYSTEM;
            default: ;
         endcase
         expected_encodings.push_back(r);
         clear_sample();
      endfunction

      function void compare_field(string name, logic [1:0] want, logic [1:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [7:0] d);
         sniff_result_type got, want;
         got = d;
         if (expected_encodings.size() == 0) begin
            $error("result beat %h with nothing expected", d);
            errors++;
            return;
         end
         want = expected_encodings.pop_front();
         compare_field("encoding_code", want.encoding, got.encoding);
         compare_field("bom_length", want.bom_length, got.bom_length);
         compare_field("unit_size", want.unit_size, got.unit_size);
         compare_field("zero fill", want.pad, got.pad);
      endfunction
   endclass

   // mode values the block must treat as plain utf8
   localparam logic [2:0]  MODE_UNUSED_LO = 3'd5;
   localparam logic [2:0]  MODE_UNUSED_HI = 3'd7;
   localparam int unsigned CYCLE_LIMIT    = 1_500_000;
   localparam int unsigned HOLD_CYCLES    = 400;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_we     = 1'b0;
   logic [2:0] csr_wdata  = 3'd0;
   logic       req_tvalid = 1'b0;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tready = 1'b0;
   logic       req_tready;
   logic       rsp_tvalid;
   logic [7:0] rsp_tdata;

   bit          idle_on      = 1'b1;   // random bubbles on both sides
   bit          hold_request = 1'b0;   // asks the receiver for one long hold-off
   int unsigned hold_left    = 0;
   int unsigned cycle_count  = 0;

   sniff_scoreboard encoding_board = new();

   text_encoding_sniffer DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: check each accepted beat, then pick next cycle's tready.
   // Values read right after the edge are the ones the edge sampled.
   initial begin
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) encoding_board.check_result(rsp_tdata);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            // long hold-off so the result register fills and input stalls
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES - 1;
            rsp_tready  <= 1'b0;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(0, 99) < 16);
         end
      end
   end

   // One beat on the input side; returns in the step of its acceptance.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (idle_on && $urandom_range(0, 99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      encoding_board.note_byte(b, last);
   endtask

   task automatic send_sample(input logic [7:0] s[$]);
      foreach (s[i]) send_byte(s[i], i == s.size() - 1);
   endtask

   // Stop offering and let every predicted result come back.
   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (encoding_board.pending() != 0) @(posedge clock);
   endtask

   // Mode writes only with no sample in flight and the result path empty.
   task automatic set_mode(input logic [2:0] m);
      wait_drain();
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= m;
      @(posedge clock);
      csr_we    <= 1'b0;
      encoding_board.set_mode(m);
   endtask

   function automatic logic [7:0] any_cont();
      return 8'($urandom_range(8'h80, 8'hBF));
   endfunction

   // One well-formed UTF-8 character, biased to ASCII, hitting range edges.
   function automatic void append_utf8(ref logic [7:0] s[$]);
      logic [7:0] lead;
      case ($urandom_range(0, 7))
         0: begin
            s.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            s.push_back(any_cont());
         end
         1: begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            s.push_back(lead);
            if (lead == 8'hE0) s.push_back(8'($urandom_range(8'hA0, 8'hBF)));
            else if (lead == 8'hED) s.push_back(8'($urandom_range(8'h80, 8'h9F)));
            else s.push_back(any_cont());
            s.push_back(any_cont());
         end
         2: begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            s.push_back(lead);
            if (lead == 8'hF0) s.push_back(8'($urandom_range(8'h90, 8'hBF)));
            else if (lead == 8'hF4) s.push_back(8'($urandom_range(8'h80, 8'h8F)));
            else s.push_back(any_cont());
            s.push_back(any_cont());
            s.push_back(any_cont());
         end
         default: s.push_back(8'($urandom_range(0, 127)));
      endcase
   endfunction

   // Random samples under one mode until the byte budget is spent.
   task automatic run_phase(input logic [2:0] m, input int unsigned budget,
                            input bit idle, input bit hold);
      logic [7:0]  s[$];
      logic [7:0]  lo;
      int unsigned sent;
      int unsigned reps;
      int unsigned kind;
      bit          be;
      set_mode(m);
      idle_on = idle;
      if (hold) hold_request = 1'b1;
      sent = 0;
      while (sent < budget) begin
         s.delete();
         // optional byte order mark, full or cut short
         case ($urandom_range(0, 9))
            0: s = {8'hEF, 8'hBB, 8'hBF};
            1: s = {8'hFF, 8'hFE};
            2: s = {8'hFE, 8'hFF};
            3: s = {8'hEF, 8'hBB};
            default: ;
         endcase
         kind = $urandom_range(0, 9);
         reps = $urandom_range(0, 10);
         if (kind < 6) begin
            repeat (reps) append_utf8(s);
         end else if (kind < 8) begin
            // 16-bit text: mostly ASCII units, zero high byte
            be = 1'($urandom_range(0, 1));
            repeat (reps) begin
               lo = 8'($urandom_range(1, 127));
               if ($urandom_range(0, 3) == 0) lo = 8'($urandom_range(0, 255));
               if (be) begin
                  s.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
                  s.push_back(lo);
               end else begin
                  s.push_back(lo);
                  s.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00);
               end
            end
         end else begin
            // mostly valid text with broken pieces mixed in
            repeat (reps) begin
               case ($urandom_range(0, 6))
                  0: s.push_back(8'($urandom_range(0, 255)));
                  1: begin
                     // lead bytes that can never be valid
                     if ($urandom_range(0, 1)) begin
                        s.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                        s.push_back(any_cont());
                     end else begin
                        s.push_back(8'($urandom_range(8'hF5, 8'hF7)));
                        repeat (3) s.push_back(any_cont());
                     end
                  end
                  2: s.push_back(any_cont());
                  3: begin
                     s.push_back(8'($urandom_range(8'hC2, 8'hF4)));
                     s.push_back(8'($urandom_range(0, 127)));
                  end
                  4: begin
                     // second byte outside the lead's allowed range
                     case ($urandom_range(0, 3))
                        0: s = {s, 8'hE0, 8'($urandom_range(8'h80, 8'h9F)), any_cont()};
                        1: s = {s, 8'hED, 8'($urandom_range(8'hA0, 8'hBF)), any_cont()};
                        2: s = {s, 8'hF0, 8'($urandom_range(8'h80, 8'h8F)), any_cont(),
                                any_cont()};
                        default: s = {s, 8'hF4, 8'($urandom_range(8'h90, 8'hBF)),
                                      any_cont(), any_cont()};
                     endcase
                  end
                  default: append_utf8(s);
               endcase
            end
         end
         // sample cut inside a sequence, sometimes with an error already in it
         case ($urandom_range(0, 7))
            0: s.push_back(8'($urandom_range(8'hC0, 8'hF7)));
            1: s = {s, 8'hE0, 8'h80};
            2: s = {s, 8'hF1, any_cont()};
            default: ;
         endcase
         if (s.size() == 0) s.push_back(8'($urandom_range(0, 255)));
         send_sample(s);
         sent += s.size();
      end
   endtask

   initial begin
      logic [7:0] s[$];
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed samples, auto mode straight out of reset.
      s = {8'hEF, 8'hBB, 8'hBF}; send_sample(s);   // utf8 BOM
      s = {8'hFF, 8'hFE};        send_sample(s);   // utf16 le BOM
      s = {8'hFE, 8'hFF};        send_sample(s);   // utf16 be BOM
      s = {8'h41, 8'h00};        send_sample(s);   // NUL at odd position
      s = {8'h00, 8'h41};        send_sample(s);   // NUL at even position
      s = {8'h00};               send_sample(s);   // lone NUL
      s = {8'hE2, 8'h82, 8'hAC}; send_sample(s);   // valid 3-byte char
      s = {8'hC0, 8'h80};        send_sample(s);   // overlong lead
      s = {8'h80};               send_sample(s);   // stray continuation
      s = {8'hFF};               send_sample(s);   // never-valid byte, short for a BOM
      s = {8'hC3, 8'h41};        send_sample(s);   // broken sequence
      s = {8'h41, 8'hE2, 8'h82}; send_sample(s);   // sample ends mid-sequence

      // Random phases over every mode; one phase without bubbles.
      run_phase(MODE_AUTO,      250, 1'b1, 1'b0);
      run_phase(MODE_UTF8,      100, 1'b0, 1'b0);
      run_phase(MODE_UTF16L,     80, 1'b1, 1'b0);
      run_phase(MODE_UTF16B,     80, 1'b1, 1'b0);
      run_phase(MODE_SYSTEM,     60, 1'b1, 1'b0);
      run_phase(MODE_UNUSED_HI,  40, 1'b1, 1'b0);
      run_phase(MODE_UNUSED_LO,  40, 1'b1, 1'b0);
      run_phase(MODE_AUTO,      200, 1'b1, 1'b1);

      wait_drain();
      repeat (8) @(posedge clock);
      if (encoding_board.errors == 0 && encoding_board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
